FILE: rtl/core/pip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants for the periodic image padder
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_W  = 24;   // unit-cube fraction, Q0.24
    localparam int OUT_W    = 25;   // Q1.24 coordinate, count, limit
    localparam int SRC_W    = 24;   // source index on the result
    localparam int POS_W    = 32;   // signed Q16.16 input coordinate
    localparam int SCALE_W  = 32;   // unsigned Q8.24 scale
    localparam int ORDER_N  = 7;    // number of image shift patterns

    // configuration register indexes
    localparam logic [1:0] REG_INV_BOX_SCALE = 2'd0;
    localparam logic [1:0] REG_PAD_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_IMAGE_LIMIT   = 2'd2;

    // reset values
    localparam logic [SCALE_W-1:0] INV_BOX_SCALE_RST = 32'h0100_0000;
    localparam logic [OUT_W-1:0]   PAD_THRESHOLD_RST = 25'd0;
    localparam logic [OUT_W-1:0]   IMAGE_LIMIT_RST   = 25'h100_0000;

    typedef struct packed {
        logic [SCALE_W-1:0] inv_box_scale;
        logic [OUT_W-1:0]   pad_threshold;
        logic [OUT_W-1:0]   image_limit;
    } cfg_t;

    // wrapped point handed from the multiply stage to the sequencer
    typedef struct packed {
        logic [COORD_W-1:0] p_x;
        logic [COORD_W-1:0] p_y;
        logic [COORD_W-1:0] p_z;
        logic [SRC_W-1:0]   src_idx;
    } wrap_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] out_x;
        logic [OUT_W-1:0] out_y;
        logic [OUT_W-1:0] out_z;
        logic [2:0]       shift_mask;
        logic [SRC_W-1:0] source_index;
        logic [OUT_W-1:0] image_total;
        logic             overflow;
        logic             last;
    } result_t;

    // shift mask at each place of the emission order: x, xy, y, xz, xyz, yz, z
    function automatic logic [2:0] order_mask(input logic [2:0] pos);
        logic [2:0] m;
        unique case (pos)
            3'd0:    m = 3'b001;
            3'd1:    m = 3'b011;
            3'd2:    m = 3'b010;
            3'd3:    m = 3'b101;
            3'd4:    m = 3'b111;
            3'd5:    m = 3'b110;
            3'd6:    m = 3'b100;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pip_wrap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pip_wrap
// input register, item numbering and per-axis scale multiply into the unit cube
// ----------------------------------------------------------------------------
module pip_wrap #(
    parameter int INDEX_BITS = 24
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [pip_pkg::POS_W-1:0]            pos_x,
    input  wire logic [pip_pkg::POS_W-1:0]            pos_y,
    input  wire logic [pip_pkg::POS_W-1:0]            pos_z,
    input  wire logic [pip_pkg::SCALE_W-1:0]          inv_box_scale,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output pip_pkg::wrap_item_t                       out_item
);

    localparam int PROD_W = 2 * pip_pkg::POS_W;
    localparam int FRAC_LO = 16;

    logic                          in_valid_reg;
    logic [pip_pkg::POS_W-1:0]     pos_x_reg, pos_y_reg, pos_z_reg;
    logic [INDEX_BITS-1:0]         idx_reg;
    logic [INDEX_BITS-1:0]         item_counter_reg;
    logic                          wrap_valid_reg;
    pip_pkg::wrap_item_t           wrap_reg;
    pip_pkg::wrap_item_t           wrap_next;
    logic                          advance;
    logic [PROD_W-1:0]             prod_x, prod_y, prod_z;
    logic [pip_pkg::SRC_W-1:0]     src_idx;

    assign advance  = !wrap_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    // signed Q16.16 times unsigned Q8.24, low product bits are exact
    assign prod_x = {{pip_pkg::POS_W{pos_x_reg[pip_pkg::POS_W-1]}}, pos_x_reg}
                  * {{(PROD_W-pip_pkg::SCALE_W){1'b0}}, inv_box_scale};
    assign prod_y = {{pip_pkg::POS_W{pos_y_reg[pip_pkg::POS_W-1]}}, pos_y_reg}
                  * {{(PROD_W-pip_pkg::SCALE_W){1'b0}}, inv_box_scale};
    assign prod_z = {{pip_pkg::POS_W{pos_z_reg[pip_pkg::POS_W-1]}}, pos_z_reg}
                  * {{(PROD_W-pip_pkg::SCALE_W){1'b0}}, inv_box_scale};

    generate
        if (INDEX_BITS >= pip_pkg::SRC_W) begin : g_idx_trunc
            assign src_idx = idx_reg[pip_pkg::SRC_W-1:0];
        end else begin : g_idx_ext
            assign src_idx = {{(pip_pkg::SRC_W-INDEX_BITS){1'b0}}, idx_reg};
        end
    endgenerate

    always_comb begin
        wrap_next.p_x     = prod_x[FRAC_LO+pip_pkg::COORD_W-1:FRAC_LO];
        wrap_next.p_y     = prod_y[FRAC_LO+pip_pkg::COORD_W-1:FRAC_LO];
        wrap_next.p_z     = prod_z[FRAC_LO+pip_pkg::COORD_W-1:FRAC_LO];
        wrap_next.src_idx = src_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            wrap_valid_reg   <= 1'b0;
            item_counter_reg <= '0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (in_valid && in_ready) begin
                item_counter_reg <= item_counter_reg + 1'b1;
            end
            if (advance) begin
                wrap_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            pos_z_reg <= pos_z;
            idx_reg   <= item_counter_reg;
        end
        if (advance && in_valid_reg) begin
            wrap_reg <= wrap_next;
        end
    end

    assign out_valid = wrap_valid_reg;
    assign out_item  = wrap_reg;

endmodule
`default_nettype wire

FILE: rtl/core/pip_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pip_emit
// result sequencer: wrapped point, ghost images, limit check, output register
// ----------------------------------------------------------------------------
module pip_emit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pip_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire pip_pkg::wrap_item_t           in_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output pip_pkg::result_t                   m_result
);

    logic                              item_valid_reg;
    logic                              first_reg;
    logic [pip_pkg::ORDER_N-1:0]       pend_reg;
    pip_pkg::wrap_item_t               item_reg;
    logic                              failed_flag_reg;
    logic                              failed_flag_next;
    logic [pip_pkg::OUT_W-1:0]         image_counter_reg;
    logic [pip_pkg::OUT_W-1:0]         image_counter_next;
    logic                              m_valid_reg;
    pip_pkg::result_t                  result_reg;
    pip_pkg::result_t                  result_next;

    logic                              out_free;
    logic                              step;
    logic                              done;
    logic [pip_pkg::ORDER_N-1:0]       pick;
    logic [pip_pkg::ORDER_N-1:0]       pend_next;
    logic [pip_pkg::ORDER_N-1:0]       pend_load;
    logic [2:0]                        shift;
    logic [2:0]                        below;
    logic                              load;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || (step && done);
    assign load     = in_valid && in_ready;

    // axes inside the pad band, and the images they call for
    always_comb begin
        below[0] = {1'b0, in_item.p_x} < cfg.pad_threshold;
        below[1] = {1'b0, in_item.p_y} < cfg.pad_threshold;
        below[2] = {1'b0, in_item.p_z} < cfg.pad_threshold;
        for (int k = 0; k < pip_pkg::ORDER_N; k++) begin
            pend_load[k] = (pip_pkg::order_mask(3'(k)) & ~below) == 3'b000;
        end
    end

    // earliest pending image in emission order
    always_comb begin
        pick  = pend_reg & (~pend_reg + 1'b1);
        shift = 3'b000;
        for (int k = 0; k < pip_pkg::ORDER_N; k++) begin
            if (pick[k]) begin
                shift = shift | pip_pkg::order_mask(3'(k));
            end
        end
    end

    always_comb begin
        result_next.out_x        = '0;
        result_next.out_y        = '0;
        result_next.out_z        = '0;
        result_next.shift_mask   = 3'b000;
        result_next.source_index = item_reg.src_idx;
        result_next.image_total  = image_counter_reg;
        result_next.overflow     = 1'b1;
        result_next.last         = 1'b1;
        failed_flag_next         = failed_flag_reg;
        image_counter_next       = image_counter_reg;
        pend_next                = pend_reg;
        done                     = 1'b1;
        priority if (first_reg && failed_flag_reg) begin
            // failed block: lone error result
        end else if (first_reg) begin
            result_next.out_x    = {1'b0, item_reg.p_x};
            result_next.out_y    = {1'b0, item_reg.p_y};
            result_next.out_z    = {1'b0, item_reg.p_z};
            result_next.overflow = 1'b0;
            done                 = pend_reg == '0;
            result_next.last     = done;
        end else if (image_counter_reg >= cfg.image_limit) begin
            failed_flag_next = 1'b1;
        end else begin
            image_counter_next       = image_counter_reg + 1'b1;
            pend_next                = pend_reg & ~pick;
            result_next.out_x        = {shift[0], item_reg.p_x};
            result_next.out_y        = {shift[1], item_reg.p_y};
            result_next.out_z        = {shift[2], item_reg.p_z};
            result_next.shift_mask   = shift;
            result_next.image_total  = image_counter_next;
            result_next.overflow     = 1'b0;
            done                     = pend_next == '0;
            result_next.last         = done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg    <= 1'b0;
            first_reg         <= 1'b0;
            pend_reg          <= '0;
            failed_flag_reg   <= 1'b0;
            image_counter_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= step;
            end
            if (step) begin
                failed_flag_reg   <= failed_flag_next;
                image_counter_reg <= image_counter_next;
            end
            if (in_ready) begin
                item_valid_reg <= in_valid;
            end
            // a load only happens once the current item is done
            if (load) begin
                first_reg <= 1'b1;
                pend_reg  <= pend_load;
            end else if (step) begin
                first_reg <= 1'b0;
                pend_reg  <= pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_item;
        end
        if (step) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

`ifndef SYNTHESIS
    a_failed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_flag_reg |=> failed_flag_reg)
        else $error("failed flag cleared without reset");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.overflow) |-> (result_reg.last && failed_flag_reg))
        else $error("error result not final or block not failed");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(image_counter_reg) |-> image_counter_reg == $past(image_counter_reg) + 1'b1)
        else $error("image counter jumped");

    a_image_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_free && step && !first_reg && !failed_flag_next)
        |=> (result_reg.image_total == image_counter_reg))
        else $error("image total does not match counter");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/periodic_image_padder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_image_padder
// wraps one 3d point per transaction into the unit cube and emits its ghost
// images across the periodic boundaries
// ----------------------------------------------------------------------------
//
//  channel   direction  fields (lowest bits first)
//  s_axis    in         tdata: pos_x[31:0] pos_y[63:32] pos_z[95:64]
//  m_axis    out        tdata: out_x out_y out_z shift_mask source_index
//                              image_total, pad bit; tuser: overflow;
//                              tlast: last
//  cfg       in         cfg_wr_en, cfg_index, cfg_data (no read-back)
//
//  results: an item yields 1 to 8 results, which the result sequencer emits
//  at one result per cycle while m_tready is high
//  path: an input transaction passes the input register, the multiply stage
//  register, the item register and the output register to its first result
//  reset: synchronous, active low; clears counters, the failed flag, all
//  valid flags, and restores the register defaults
//  stalls: m_tready low holds the output register; the next item waits in
//  the multiply stage and input register; only until both are full may s_tready stay high
// ----------------------------------------------------------------------------
module periodic_image_padder #(
    parameter int INDEX_BITS = 24
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,

    // input stream
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [95:0]   s_tdata,   // pos_x, pos_y, pos_z

    // result stream
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [127:0]       m_tdata,   // out_x, out_y, out_z, shift_mask,
                                          // source_index, image_total, zero pad
    output logic               m_tuser,   // overflow
    output logic               m_tlast,

    // configuration writes
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int P = pip_pkg::POS_W;

    pip_pkg::cfg_t       cfg_reg;
    logic                wrap_valid;
    logic                wrap_ready;
    pip_pkg::wrap_item_t wrap_item;
    pip_pkg::result_t    result;

    // configuration registers, masked to their widths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_box_scale <= pip_pkg::INV_BOX_SCALE_RST;
            cfg_reg.pad_threshold <= pip_pkg::PAD_THRESHOLD_RST;
            cfg_reg.image_limit   <= pip_pkg::IMAGE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pip_pkg::REG_INV_BOX_SCALE: begin
                    cfg_reg.inv_box_scale <= cfg_data;
                end
                pip_pkg::REG_PAD_THRESHOLD: begin
                    cfg_reg.pad_threshold <= cfg_data[pip_pkg::OUT_W-1:0];
                end
                pip_pkg::REG_IMAGE_LIMIT: begin
                    cfg_reg.image_limit <= cfg_data[pip_pkg::OUT_W-1:0];
                end
                default: begin
                    // unmapped index: write ignored
                end
            endcase
        end
    end

    // input register, item numbering, scale multiply and fraction pick
    pip_wrap #(
        .INDEX_BITS (INDEX_BITS)
    ) u_wrap (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .pos_x         (s_tdata[P-1:0]),
        .pos_y         (s_tdata[2*P-1:P]),
        .pos_z         (s_tdata[3*P-1:2*P]),
        .inv_box_scale (cfg_reg.inv_box_scale),
        .out_valid     (wrap_valid),
        .out_ready     (wrap_ready),
        .out_item      (wrap_item)
    );

    // pad test, image sequencing, limit check and output register
    pip_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (wrap_valid),
        .in_ready (wrap_ready),
        .in_item  (wrap_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // pack results, lowest field first
    assign m_tdata = {1'b0,
                      result.image_total,
                      result.source_index,
                      result.shift_mask,
                      result.out_z,
                      result.out_y,
                      result.out_x};
    assign m_tuser = result.overflow;
    assign m_tlast = result.last;

endmodule
`default_nettype wire

FILE: tb/pip_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pip_checker
// watches both streams and the register port of the periodic image padder,
// predicts every result of each input transaction and compares them in order
// ----------------------------------------------------------------------------
module pip_checker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    input  wire logic [95:0]   s_tdata,    // pos_x, pos_y, pos_z
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [127:0]  m_tdata,    // out_x, out_y, out_z, shift_mask,
                                           // source_index, image_total, pad
    input  wire logic          m_tuser,    // overflow
    input  wire logic          m_tlast,
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    output int                 mismatches,
    output int                 outstanding,
    output logic [pip_pkg::OUT_W-1:0] images_emitted
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pip_pkg::OUT_W-1:0] ONE_UNIT = 25'h100_0000;

    logic [pip_pkg::SCALE_W-1:0] scale_q;
    logic [pip_pkg::OUT_W-1:0]   pad_q;
    logic [pip_pkg::OUT_W-1:0]   limit_q;
    logic [pip_pkg::SRC_W-1:0]   point_idx;
    logic [pip_pkg::OUT_W-1:0]   image_cnt;
    logic                        failed;
    pip_pkg::result_t            pending_images[$];

    // fraction of pos times scale, product has 40 fraction bits
    function automatic logic [pip_pkg::COORD_W-1:0] wrap_axis(
        input logic [pip_pkg::POS_W-1:0] pos);
        logic [63:0] prod;
        prod = {{32{pos[pip_pkg::POS_W-1]}}, pos} * {32'd0, scale_q};
        return prod[39:16];
    endfunction

    function automatic pip_pkg::result_t image_result(
        input logic [pip_pkg::OUT_W-1:0] x,
        input logic [pip_pkg::OUT_W-1:0] y,
        input logic [pip_pkg::OUT_W-1:0] z,
        input logic [2:0]                mask,
        input logic [pip_pkg::SRC_W-1:0] idx,
        input logic                      ovf,
        input logic                      fin);
        pip_pkg::result_t r;
        r.out_x        = x;
        r.out_y        = y;
        r.out_z        = z;
        r.shift_mask   = mask;
        r.source_index = idx;
        r.image_total  = image_cnt;
        r.overflow     = ovf;
        r.last         = fin;
        return r;
    endfunction

    task automatic predict_images(input logic [95:0] data);
        logic [pip_pkg::COORD_W-1:0] p [3];
        logic [2:0]                  order [7];
        logic [pip_pkg::SRC_W-1:0]   idx;
        logic [2:0]                  m;
        int                          n;
        int                          prior;
        idx       = point_idx;
        point_idx = point_idx + 1'b1;
        if (failed) begin
            pending_images.push_back(image_result('0, '0, '0, 3'd0, idx, 1'b1, 1'b1));
            return;
        end
        for (int a = 0; a < 3; a++) begin
            p[a] = wrap_axis(data[pip_pkg::POS_W*a +: pip_pkg::POS_W]);
        end
        // every padded axis pairs with all the shifts listed so far
        n = 0;
        for (int a = 0; a < 3; a++) begin
            if ({1'b0, p[a]} < pad_q) begin
                prior = n;
                for (int j = 0; j < prior; j++) begin
                    order[n] = order[j] | (3'b001 << a);
                    n = n + 1;
                end
                order[n] = 3'b001 << a;
                n = n + 1;
            end
        end
        pending_images.push_back(image_result({1'b0, p[0]}, {1'b0, p[1]}, {1'b0, p[2]},
                                              3'd0, idx, 1'b0, n == 0));
        for (int j = 0; j < n; j++) begin
            if (image_cnt >= limit_q) begin
                failed = 1'b1;
                pending_images.push_back(image_result('0, '0, '0, 3'd0, idx, 1'b1, 1'b1));
                return;
            end
            image_cnt = image_cnt + 1'b1;
            m = order[j];
            pending_images.push_back(image_result(
                {1'b0, p[0]} + (m[0] ? ONE_UNIT : '0),
                {1'b0, p[1]} + (m[1] ? ONE_UNIT : '0),
                {1'b0, p[2]} + (m[2] ? ONE_UNIT : '0),
                m, idx, 1'b0, j == n - 1));
        end
    endtask

    task automatic compare_result(input pip_pkg::result_t exp, input pip_pkg::result_t got);
        if (got.out_x !== exp.out_x) begin
            $error("out_x expected %0h got %0h", exp.out_x, got.out_x);
            mismatches++;
        end
        if (got.out_y !== exp.out_y) begin
            $error("out_y expected %0h got %0h", exp.out_y, got.out_y);
            mismatches++;
        end
        if (got.out_z !== exp.out_z) begin
            $error("out_z expected %0h got %0h", exp.out_z, got.out_z);
            mismatches++;
        end
        if (got.shift_mask !== exp.shift_mask) begin
            $error("shift_mask expected %0h got %0h", exp.shift_mask, got.shift_mask);
            mismatches++;
        end
        if (got.source_index !== exp.source_index) begin
            $error("source_index expected %0h got %0h", exp.source_index, got.source_index);
            mismatches++;
        end
        if (got.image_total !== exp.image_total) begin
            $error("image_total expected %0h got %0h", exp.image_total, got.image_total);
            mismatches++;
        end
        if (got.overflow !== exp.overflow) begin
            $error("overflow expected %0h got %0h", exp.overflow, got.overflow);
            mismatches++;
        end
        if (got.last !== exp.last) begin
            $error("last expected %0h got %0h", exp.last, got.last);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        pip_pkg::result_t got;
        if (!aresetn) begin
            scale_q    = pip_pkg::INV_BOX_SCALE_RST;
            pad_q      = pip_pkg::PAD_THRESHOLD_RST;
            limit_q    = pip_pkg::IMAGE_LIMIT_RST;
            point_idx  = '0;
            image_cnt  = '0;
            failed     = 1'b0;
            mismatches = 0;
            pending_images.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    pip_pkg::REG_INV_BOX_SCALE: scale_q = cfg_data[pip_pkg::SCALE_W-1:0];
                    pip_pkg::REG_PAD_THRESHOLD: pad_q   = cfg_data[pip_pkg::OUT_W-1:0];
                    pip_pkg::REG_IMAGE_LIMIT:   limit_q = cfg_data[pip_pkg::OUT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_images(s_tdata);
            if (m_tvalid && m_tready) begin
                got.out_x        = m_tdata[24:0];
                got.out_y        = m_tdata[49:25];
                got.out_z        = m_tdata[74:50];
                got.shift_mask   = m_tdata[77:75];
                got.source_index = m_tdata[101:78];
                got.image_total  = m_tdata[126:102];
                got.overflow     = m_tuser;
                got.last         = m_tlast;
                if (pending_images.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    mismatches++;
                end else begin
                    compare_result(pending_images.pop_front(), got);
                end
            end
        end
        outstanding    = pending_images.size();
        images_emitted = image_cnt;
    end

endmodule
`default_nettype wire

FILE: tb/periodic_image_padder_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_image_padder_test
// drives positions and register settings into the padder with random gaps
// and output stalls; a checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
module periodic_image_padder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 300;   // long output hold-off
    localparam int DRAIN_CYCLES  = 8;     // pause after the last result
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_POINTS  = 55;
    localparam int SENDER        = 0;
    localparam int RECEIVER      = 1;

    // handy Q16.16 positions
    localparam logic [31:0] QUARTER        = 32'h0000_4000;
    localparam logic [31:0] THREE_QUARTERS = 32'h0000_C000;
    localparam logic [31:0] NEG_3Q         = 32'hFFFF_4000;  // -0.75
    localparam logic [31:0] ONE_Q16        = 32'h0001_0000;
    localparam logic [31:0] POS_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] POS_MIN        = 32'h8000_0000;
    localparam logic [31:0] MINUS_LSB      = 32'hFFFF_FFFF;

    localparam logic [31:0] SCALE_ONE      = 32'h0100_0000;
    localparam logic [31:0] SCALE_MAX      = 32'hFFFF_FFFF;
    localparam logic [31:0] PAD_FULL       = 32'h0100_0000;
    localparam logic [31:0] LIMIT_FULL     = 32'h0100_0000;
    localparam logic [31:0] HIGH_JUNK      = 32'hFE00_0000;  // above 25-bit regs

    logic          aclk;
    logic          aresetn   = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [95:0]   s_tdata   = '0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [127:0]  m_tdata;
    logic          m_tuser;
    logic          m_tlast;
    logic          cfg_wr_en = 1'b0;
    logic [1:0]    cfg_index = pip_pkg::REG_INV_BOX_SCALE;
    logic [31:0]   cfg_data  = '0;

    int                        mismatches;
    int                        outstanding;
    logic [pip_pkg::OUT_W-1:0] images_emitted;
    int                        cycle_count = 0;
    int                        calm_left [2] = '{0, 0};
    bit                        hold_output = 1'b0;

    periodic_image_padder #(.INDEX_BITS(24)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pip_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .images_emitted (images_emitted)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // wait before one transaction: mostly a random gap, now and then a calm
    // run of back-to-back transactions
    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side] = calm_left[side] - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left[side] = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // mix of full-range, near-zero, integer-plus-small-fraction and edge values
    function automatic logic [31:0] random_coord();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0003_FFFF);
            2: begin
                case ($urandom_range(0, 4))
                    0: v = POS_MAX;
                    1: v = POS_MIN;
                    2: v = MINUS_LSB;
                    3: v = ONE_Q16;
                    default: v = '0;
                endcase
            end
            default: v = ($urandom_range(0, 255) << 16) | $urandom_range(0, 32'h1FFF);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    // one input transaction, tvalid stays high when the next follows at once
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        int gap;
        gap = draw_wait(SENDER);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // all three registers back to back, only while the block is idle
    task automatic write_config(input logic [31:0] scale, input logic [31:0] pad,
                                input logic [31:0] limit);
        cfg_wr_en <= 1'b1;
        cfg_index <= pip_pkg::REG_INV_BOX_SCALE;
        cfg_data  <= scale;
        @(posedge aclk);
        cfg_index <= pip_pkg::REG_PAD_THRESHOLD;
        cfg_data  <= pad;
        @(posedge aclk);
        cfg_index <= pip_pkg::REG_IMAGE_LIMIT;
        cfg_data  <= limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // stop offering and wait until every predicted result has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // receiver: random stall before each result, long hold-off on request
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
            end
            stall = draw_wait(RECEIVER);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        logic [31:0] scale;
        logic [31:0] pad;
        logic [31:0] limit;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: unit box, no padding, so only wrapped points
        send_point('0, '0, '0);
        send_point(POS_MAX, POS_MIN, MINUS_LSB);
        send_point(POS_MIN, MINUS_LSB, POS_MAX);
        send_point(ONE_Q16, NEG_3Q, QUARTER);
        send_point(MINUS_LSB, POS_MAX, POS_MIN);
        send_point(THREE_QUARTERS, ONE_Q16, NEG_3Q);
        wait_drained();

        // largest scale, threshold with junk above bit 24: every axis pads
        write_config(SCALE_MAX, SCALE_MAX, HIGH_JUNK | LIMIT_FULL);
        send_point(POS_MAX, POS_MAX, POS_MAX);
        send_point(POS_MIN, POS_MIN, POS_MIN);
        send_point('0, MINUS_LSB, ONE_Q16);
        send_point(MINUS_LSB, QUARTER, POS_MIN);
        wait_drained();

        // half-unit threshold, every subset of padded axes, one negative wrap
        write_config(SCALE_ONE, 32'h0080_0000, LIMIT_FULL);
        for (int c = 0; c < 8; c++) begin
            send_point(c[0] ? QUARTER : THREE_QUARTERS,
                       c[1] ? QUARTER : THREE_QUARTERS,
                       c[2] ? QUARTER : THREE_QUARTERS);
        end
        send_point(NEG_3Q, THREE_QUARTERS, NEG_3Q);
        wait_drained();

        // zero scale and limit: no threshold is met, so the limit is never hit
        write_config('0, '0, '0);
        send_point(POS_MAX, POS_MIN, QUARTER);
        send_point(MINUS_LSB, '0, THREE_QUARTERS);
        wait_drained();

        // random settings, limit always well above the images of the run
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: scale = $urandom;
                1: scale = SCALE_ONE + $urandom_range(0, 32'hFFFF) - 32'h8000;
                2: scale = $urandom_range(0, 32'h00FF_FFFF);
                default: scale = $urandom_range(SCALE_ONE, 32'h0800_0000);
            endcase
            case ($urandom_range(0, 3))
                0: pad = $urandom_range(0, PAD_FULL);
                1: pad = '0;
                2: pad = PAD_FULL;
                default: pad = $urandom_range(0, 32'h0040_0000);
            endcase
            if ($urandom_range(0, 2) == 0) pad = pad | ($urandom & HIGH_JUNK);
            limit = $urandom_range(0, 1) ? LIMIT_FULL : $urandom_range(4096, LIMIT_FULL);
            write_config(scale, pad, limit);
            // first random phase: output held off while input keeps coming
            if (ph == 0) hold_output = 1'b1;
            for (int i = 0; i < PHASE_POINTS; i++) begin
                send_point(random_coord(), random_coord(), random_coord());
            end
            wait_drained();
        end

        // limit two images above the count with every axis padded: the first
        // item breaks off mid-way, all later ones give only the error result
        write_config($urandom, PAD_FULL, 32'(images_emitted) + 32'd2);
        for (int i = 0; i < 12; i++) begin
            send_point(random_coord(), random_coord(), random_coord());
        end
        wait_drained();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
